### rtl/core/point_polyline_distance_squared_macros.svh
// assertion macros for the point to polyline distance block
`ifndef POINT_POLYLINE_DISTANCE_SQUARED_MACROS_SVH
`define POINT_POLYLINE_DISTANCE_SQUARED_MACROS_SVH
`ifndef SYNTHESIS
`define PPDS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ppds assertion failed");
`define PPDS_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("ppds forbidden condition");
`else
`define PPDS_ASSERT(label, clk, rst_n, prop)
`define PPDS_NEVER(label, clk, rst_n, expr)
`endif
`endif

### rtl/core/ppds_pkg.sv
// shared constants and types for the point to polyline distance block
package ppds_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned OUT_W = 34;
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_THREE_D_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_CHECK,
    ST_SQR,
    ST_DINIT,
    ST_DIV,
    ST_FOLD,
    ST_EMIT
  } back_state_e;
endpackage

### rtl/core/ppds_front.sv
// front end: accepts vertices, tracks polyline state and forms segment differences
module ppds_front #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned JOB_W = 9 * (COORD_BITS + 1) + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         three_d_mode_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_z_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] query_z_i,
  input  logic                         first_vertex_i,
  input  logic                         last_vertex_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output logic [JOB_W-1:0]             job_o
);
  localparam int unsigned DW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic signed [COORD_BITS-1:0] pnt_x_q, pnt_y_q, pnt_z_q;
  logic signed [COORD_BITS-1:0] px, py, pz;
  logic signed [DW-1:0] wx, wy, wz, ex, ey, ez, dx, dy, dz;
  logic accept;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i & job_ready_i;

  always_comb begin
    px = first_vertex_i ? query_x_i : pnt_x_q;
    py = first_vertex_i ? query_y_i : pnt_y_q;
    pz = first_vertex_i ? query_z_i : pnt_z_q;
    ex = DW'(px) - DW'(vertex_x_i);
    ey = DW'(py) - DW'(vertex_y_i);
    ez = three_d_mode_i ? (DW'(pz) - DW'(vertex_z_i)) : '0;
    dx = DW'(vertex_x_i) - DW'(prev_x_q);
    dy = DW'(vertex_y_i) - DW'(prev_y_q);
    dz = three_d_mode_i ? (DW'(vertex_z_i) - DW'(prev_z_q)) : '0;
    // first vertex: distance to the vertex itself
    if (first_vertex_i) begin
      wx = ex;
      wy = ey;
      wz = ez;
    end else begin
      wx = DW'(px) - DW'(prev_x_q);
      wy = DW'(py) - DW'(prev_y_q);
      wz = three_d_mode_i ? (DW'(pz) - DW'(prev_z_q)) : '0;
    end
  end

  assign job_o = {first_vertex_i, last_vertex_i, wx, wy, wz, ex, ey, ez, dx, dy, dz};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_z_q <= '0;
      pnt_x_q  <= '0;
      pnt_y_q  <= '0;
      pnt_z_q  <= '0;
    end else if (accept) begin
      prev_x_q <= vertex_x_i;
      prev_y_q <= vertex_y_i;
      prev_z_q <= vertex_z_i;
      if (first_vertex_i) begin
        pnt_x_q <= query_x_i;
        pnt_y_q <= query_y_i;
        pnt_z_q <= query_z_i;
      end
    end
  end
endmodule

### rtl/core/ppds_fifo.sv
// two entry queue between front and back
module ppds_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output logic [W-1:0] rd_data_o
);
  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i & wr_ready_o;
  assign do_rd      = rd_valid_o & rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule

### rtl/core/ppds_back.sv
// back end: shared multiplier, serial divider and running minimum
`include "point_polyline_distance_squared_macros.svh"
module ppds_back #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned JOB_W = 9 * (COORD_BITS + 1) + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  output logic                      job_ready_o,
  input  logic [JOB_W-1:0]          job_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ppds_pkg::OUT_W-1:0] distance_squared_o
);
  import ppds_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned H = COORD_BITS + 1;
  localparam int unsigned MW = COORD_BITS + 2;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned ACC_W = 2 * COORD_BITS + 3;
  localparam int unsigned SQ_W = 4 * H;
  localparam int unsigned CW = $clog2(2 * H);
  localparam int unsigned SW = (2 * H > OUT_W) ? 2 * H : OUT_W;

  back_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic signed [DW-1:0] w_q [3];
  logic signed [DW-1:0] e_q [3];
  logic signed [DW-1:0] d_q [3];
  logic signed [DW-1:0] w_n [3];
  logic signed [DW-1:0] e_n [3];
  logic signed [DW-1:0] d_n [3];
  logic first_q, last_q;
  logic signed [ACC_W-1:0] acc_q [4];
  logic [SQ_W-1:0] sq_q, sq_d;
  logic [2*H-1:0] rem_q, rem_d, quo_q, quo_d, res_q, res_d;
  logic [OUT_W-1:0] min_q, min_d, out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;
  logic [1:0] grp, comp;
  logic [2*H-1:0] w2, e2, len2, dot_u, dot_lo_ext, dot_hi_ext;
  logic [2*H:0] r2;
  logic [SW-1:0] res_ext;
  logic [OUT_W-1:0] res_sat;
  logic mac_en, load;

  assign grp  = cnt_q[3:2];
  assign comp = cnt_q[1:0];
  assign w2    = acc_q[0][2*H-1:0];
  assign e2    = acc_q[1][2*H-1:0];
  assign len2  = acc_q[2][2*H-1:0];
  assign dot_u = acc_q[3][2*H-1:0];
  assign dot_lo_ext = {{H{1'b0}}, dot_u[H-1:0]};
  assign dot_hi_ext = {{H{1'b0}}, dot_u[2*H-1:H]};

  always_comb begin
    {w_n[0], w_n[1], w_n[2], e_n[0], e_n[1], e_n[2], d_n[0], d_n[1], d_n[2]} =
      job_i[JOB_W-3:0];
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_q == ST_SQR) begin
      case (cnt_q[1:0])
        2'd0: begin
          op_a = MW'(dot_lo_ext[H-1:0]);
          op_b = MW'(dot_lo_ext[H-1:0]);
        end
        2'd1: begin
          op_a = MW'(dot_lo_ext[H-1:0]);
          op_b = MW'(dot_hi_ext[H-1:0]);
        end
        default: begin
          op_a = MW'(dot_hi_ext[H-1:0]);
          op_b = MW'(dot_hi_ext[H-1:0]);
        end
      endcase
    end else if (comp != 2'd3) begin
      case (grp)
        2'd0: begin
          op_a = MW'(w_q[comp]);
          op_b = MW'(w_q[comp]);
        end
        2'd1: begin
          op_a = MW'(e_q[comp]);
          op_b = MW'(e_q[comp]);
        end
        2'd2: begin
          op_a = MW'(d_q[comp]);
          op_b = MW'(d_q[comp]);
        end
        default: begin
          op_a = MW'(w_q[comp]);
          op_b = MW'(d_q[comp]);
        end
      endcase
    end
  end

  assign prod = op_a * op_b;

  assign r2 = {rem_q, sq_q[2*H-1]};
  assign res_ext = SW'(res_q);
  assign res_sat = (res_ext > SW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : res_ext[OUT_W-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    res_d       = res_q;
    min_d       = min_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    job_ready_o = 1'b0;
    mac_en      = 1'b0;
    load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          load    = 1'b1;
          cnt_d   = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_en = 1'b1;
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == CW'(15)) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cnt_d = '0;
        if (first_q || len2 == '0 || acc_q[3][ACC_W-1]) begin
          res_d   = w2;
          state_d = ST_FOLD;
        end else if (dot_u > len2) begin
          res_d   = e2;
          state_d = ST_FOLD;
        end else begin
          sq_d    = '0;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        case (cnt_q[1:0])
          2'd0: sq_d = sq_q + SQ_W'(prod[2*H-1:0]);
          2'd1: sq_d = sq_q + (SQ_W'(prod[2*H-1:0]) << (H + 1));
          default: sq_d = sq_q + (SQ_W'(prod[2*H-1:0]) << (2 * H));
        endcase
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(2)) state_d = ST_DINIT;
      end
      ST_DINIT: begin
        rem_d   = sq_q[SQ_W-1:2*H];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        sq_d = {sq_q[SQ_W-1:2*H], sq_q[2*H-2:0], 1'b0};
        if (r2 >= {1'b0, len2}) begin
          rem_d = (2 * H)'(r2 - {1'b0, len2});
          quo_d = {quo_q[2*H-2:0], 1'b1};
        end else begin
          rem_d = r2[2*H-1:0];
          quo_d = {quo_q[2*H-2:0], 1'b0};
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(2 * H - 1)) begin
          res_d   = w2 - quo_d;
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (first_q || res_sat < min_q) min_d = res_sat;
        state_d = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = min_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      min_q       <= {OUT_W{1'b1}};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q  <= sq_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    res_q <= res_d;
    out_q <= out_d;
    if (load) begin
      first_q <= job_i[JOB_W-1];
      last_q  <= job_i[JOB_W-2];
      for (int i = 0; i < 3; i++) begin
        w_q[i] <= w_n[i];
        e_q[i] <= e_n[i];
        d_q[i] <= d_n[i];
      end
      for (int i = 0; i < 4; i++) begin
        acc_q[i] <= '0;
      end
    end else if (mac_en) begin
      acc_q[grp] <= acc_q[grp] + ACC_W'(prod);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign distance_squared_o = out_q;

  `PPDS_ASSERT(a_div_rem_below_len, clk_i, rst_ni, (state_q == ST_DIV) |-> (rem_q < len2))
  `PPDS_ASSERT(a_min_not_rising, clk_i, rst_ni,
    (state_q == ST_FOLD && !first_q) |=> (min_q <= $past(min_q)))
  `PPDS_ASSERT(a_emit_free_slot, clk_i, rst_ni,
    (state_q == ST_EMIT && !out_valid_q) |=> out_valid_q)
  `PPDS_NEVER(a_no_take_while_busy, clk_i, rst_ni, job_ready_o && state_q != ST_IDLE)
endmodule

### rtl/core/point_polyline_distance_squared.sv
// back end states per vertex: idle, mac, check and fold, with squaring, divider init and divider when projecting
// projection path: 16 mac steps, 3 squaring steps and 2*COORD_BITS+2 divider steps
// throughput: one vertex per back end run; the two entry queue lets the front keep taking
// vertices while the back end works, so the sustained rate is set by the shared multiplier
// and the radix-2 divider; a last vertex also passes through the emit state
// reset: async active low; state zero, running minimum all ones, three_d_mode set
module point_polyline_distance_squared #(
  parameter int unsigned COORD_BITS = ppds_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_BITS-1:0]  vertex_x_i,
  input  logic signed [COORD_BITS-1:0]  vertex_y_i,
  input  logic signed [COORD_BITS-1:0]  vertex_z_i,
  input  logic signed [COORD_BITS-1:0]  query_x_i,
  input  logic signed [COORD_BITS-1:0]  query_y_i,
  input  logic signed [COORD_BITS-1:0]  query_z_i,
  input  logic                          first_vertex_i,
  input  logic                          last_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ppds_pkg::OUT_W-1:0]    distance_squared_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppds_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ppds_pkg::*;

  localparam int unsigned JOB_W = 9 * (COORD_BITS + 1) + 2;

  logic mode_q;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  logic [JOB_W-1:0] fj_data, bj_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THREE_D_MODE) ? {31'b0, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_THREE_D_MODE) begin
      mode_q <= pwdata[0];
    end
  end

  ppds_front #(.COORD_BITS(COORD_BITS), .JOB_W(JOB_W)) u_front (
    .clk_i, .rst_ni,
    .three_d_mode_i (mode_q),
    .in_valid_i, .in_ready_o,
    .vertex_x_i, .vertex_y_i, .vertex_z_i,
    .query_x_i, .query_y_i, .query_z_i,
    .first_vertex_i, .last_vertex_i,
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj_data)
  );

  ppds_fifo #(.W(JOB_W)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i (fj_valid),
    .wr_ready_o (fj_ready),
    .wr_data_i  (fj_data),
    .rd_valid_o (bj_valid),
    .rd_ready_i (bj_ready),
    .rd_data_o  (bj_data)
  );

  ppds_back #(.COORD_BITS(COORD_BITS), .JOB_W(JOB_W)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_i       (bj_data),
    .out_valid_o, .out_ready_i,
    .distance_squared_o
  );
endmodule
